// ===== sv/rmf_pkg.sv =====
// Shared types, constants and codes of the routed message framer.
package rmf_pkg;

    localparam int FRAME_BYTES_DEF   = 32;
    localparam int MAX_SUBFRAMES_DEF = 4;
    localparam int MAX_HOPS_DEF      = 8;

    // Upper end of the hop range; the command byte list is sized for it.
    localparam int MAX_HOPS_LIMIT = 16;
    localparam int LIST_LEN       = (MAX_HOPS_LIMIT + 5) / 4 + 1;
    localparam int LIST_CW        = $clog2(LIST_LEN + 1);
    localparam int LIST_IW        = $clog2(LIST_LEN);

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 3;

    localparam logic [CFG_IW-1:0] REG_TYPE_CODE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_ROUTE_END = 2'd1;

    localparam logic [2:0] TYPE_CODE_RST = 3'd2;
    localparam logic [1:0] ROUTE_END_RST = 2'd3;

    // First stream byte slot of a sub-message, after header and id.
    localparam logic [4:0] POS_FIRST = 5'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERR,
        BK_HDR,
        BK_ID,
        BK_DATA,
        BK_PAD
    } back_state_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  message_id;
        logic [7:0]  payload_length;
        logic [15:0] route_hops;
        logic [3:0]  route_count;
        logic [7:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
        logic       overflow_error;
    } result_t;

    // One classified transaction, handed from the front to the back.
    typedef struct packed {
        cmd_kind_t                 kind;
        logic [7:0]                id;
        logic [2:0]                count;
        logic                      finish;
        logic [LIST_CW-1:0]        nbytes;
        logic [LIST_LEN-1:0][7:0]  bytes;
    } cmd_t;

endpackage

// ===== sv/rmf_front.sv =====
// Front end: accepts input transactions, packs symbols into stream bytes, sizes messages.
module rmf_front #(
    parameter int MAX_HOPS      = rmf_pkg::MAX_HOPS_DEF,
    parameter int FRAME_BYTES   = rmf_pkg::FRAME_BYTES_DEF,
    parameter int MAX_SUBFRAMES = rmf_pkg::MAX_SUBFRAMES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  rmf_pkg::item_t item,
    input  logic [1:0]     route_end,
    input  logic           cmd_full,
    output logic           cmd_push,
    output rmf_pkg::cmd_t  cmd
);
    import rmf_pkg::*;

    localparam int CAP = FRAME_BYTES - 2;
    localparam logic [4:0] HOP_CAP = 5'(MAX_HOPS);

    logic [7:0] pack_reg, pack_next;
    logic [1:0] slot_reg, slot_next;
    logic       busy_reg, busy_next;
    logic [7:0] left_reg, left_next;

    logic [4:0]  cnt_eff;
    logic [4:0]  sym_total;
    logic [2:0]  nb;
    logic [1:0]  slot_new;
    logic [1:0]  sym [4*LIST_LEN];
    logic [LIST_LEN-1:0][7:0] start_bytes;
    logic [15:0] hop_shift;
    logic [7:0]  len_shift;
    logic [8:0]  sbytes;
    logic        overflow;
    logic [2:0]  frames;
    logic        start_finish;
    logic [15:0] data_word;
    logic        data_finish;
    logic        accept;

    assign item_stall = cmd_full;
    assign accept     = item_valid && !cmd_full;

    // Symbol stream of a start transaction: hops, end mark, length.
    always_comb
    begin
        int m;
        m         = 0;
        cnt_eff   = ({1'b0, item.route_count} > HOP_CAP) ? HOP_CAP : {1'b0, item.route_count};
        sym_total = cnt_eff + 5'd5;
        nb        = sym_total[4:2];
        slot_new  = sym_total[1:0];
        hop_shift = '0;
        len_shift = '0;
        for (int k = 0; k < 4*LIST_LEN; k++)
        begin
            sym[k] = 2'b00;
            if (k < int'(cnt_eff))
            begin
                hop_shift = item.route_hops << (2*k);
                sym[k]    = hop_shift[15:14];
            end
            else if (k == int'(cnt_eff))
            begin
                sym[k] = route_end;
            end
            else if (k < int'(sym_total))
            begin
                m         = k - int'(cnt_eff) - 1;
                len_shift = item.payload_length << (2*m);
                sym[k]    = len_shift[7:6];
            end
        end
        for (int b = 0; b < LIST_LEN; b++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                start_bytes[b][7-2*s -: 2] = sym[4*b+s];
            end
        end
    end

    // Sub-message count by compare against multiples of the frame capacity.
    always_comb
    begin
        sbytes   = {1'b0, item.payload_length} + 9'((cnt_eff + 5'd8) >> 2);
        overflow = sbytes > 9'(MAX_SUBFRAMES * CAP);
        frames   = 3'd1;
        for (int k = 1; k < MAX_SUBFRAMES; k++)
        begin
            if (sbytes > 9'(k * CAP))
            begin
                frames = frames + 3'd1;
            end
        end
    end

    assign start_finish = (item.payload_length == 8'd0);
    assign data_word    = {item.payload_byte, 8'h00} >> {slot_reg, 1'b0};
    assign data_finish  = (left_reg == 8'd1);

    always_comb
    begin
        pack_next = pack_reg;
        slot_next = slot_reg;
        busy_next = busy_reg;
        left_next = left_reg;
        cmd_push  = 1'b0;
        cmd       = '0;
        if (accept)
        begin
            if (item.op == OP_START)
            begin
                cmd_push = 1'b1;
                cmd.id   = item.message_id;
                cmd.count = frames;
                if (overflow)
                begin
                    cmd.kind  = CMD_ERROR;
                    busy_next = 1'b0;
                    pack_next = '0;
                    slot_next = '0;
                    left_next = '0;
                end
                else
                begin
                    cmd.kind   = CMD_START;
                    cmd.finish = start_finish;
                    cmd.bytes  = start_bytes;
                    cmd.nbytes = LIST_CW'(nb)
                               + LIST_CW'(start_finish && (slot_new != 2'd0));
                    left_next  = item.payload_length;
                    busy_next  = !start_finish;
                    pack_next  = start_finish ? 8'h00 : start_bytes[LIST_IW'(nb)];
                    slot_next  = start_finish ? 2'd0 : slot_new;
                end
            end
            else if (busy_reg)
            begin
                cmd_push     = 1'b1;
                cmd.kind     = CMD_DATA;
                cmd.finish   = data_finish;
                cmd.bytes[0] = pack_reg | data_word[15:8];
                cmd.bytes[1] = data_word[7:0];
                cmd.nbytes   = LIST_CW'(1) + LIST_CW'(data_finish && (slot_reg != 2'd0));
                left_next    = left_reg - 8'd1;
                if (data_finish)
                begin
                    busy_next = 1'b0;
                    pack_next = '0;
                    slot_next = '0;
                end
                else
                begin
                    pack_next = data_word[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg <= '0;
            slot_reg <= '0;
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            pack_reg <= pack_next;
            slot_reg <= slot_next;
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

endmodule

// ===== sv/rmf_queue.sv =====
// Two-entry command queue between front and back.
module rmf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rmf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rmf_pkg::cmd_t head
);
    import rmf_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/rmf_back.sv =====
// Back end: frames stream bytes into sub-messages and drives the result register.
module rmf_back #(
    parameter int FRAME_BYTES = rmf_pkg::FRAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  rmf_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic [2:0]       type_code,
    output logic             result_valid,
    input  logic             result_stall,
    output rmf_pkg::result_t result
);
    import rmf_pkg::*;

    localparam logic [4:0] POS_LAST = 5'(FRAME_BYTES - 1);

    back_state_t         state_reg, state_next;
    cmd_t                cur_reg, cur_next;
    logic [LIST_IW-1:0]  idx_reg, idx_next;
    logic [4:0]          pos_reg, pos_next;
    logic [2:0]          sub_index_reg, sub_index_next;
    logic [2:0]          sub_count_reg, sub_count_next;
    logic [7:0]          held_id_reg, held_id_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic       out_free;
    logic [7:0] cur_byte;
    logic       last_byte;
    logic       at_end;
    logic [4:0] pos_after;
    logic       wraps;

    assign out_free     = !res_valid_reg || !result_stall;
    assign cur_byte     = cur_reg.bytes[idx_reg];
    assign last_byte    = (LIST_CW'(idx_reg) + LIST_CW'(1)) == cur_reg.nbytes;
    assign at_end       = (pos_reg >= POS_LAST);
    assign pos_after    = at_end ? POS_FIRST : pos_reg + 5'd1;
    assign wraps        = (pos_after == POS_FIRST);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_ERROR: state_next = BK_ERR;
                        CMD_START: state_next = BK_HDR;
                        CMD_DATA:  state_next = (pos_reg == POS_FIRST) ? BK_HDR : BK_DATA;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_ERR:
            begin
                if (out_free) state_next = BK_IDLE;
            end
            BK_HDR:
            begin
                if (out_free) state_next = BK_ID;
            end
            BK_ID:
            begin
                if (out_free) state_next = BK_DATA;
            end
            BK_DATA:
            begin
                if (out_free)
                begin
                    priority if (!last_byte)       state_next = wraps ? BK_HDR : BK_DATA;
                    else if (cur_reg.finish && !wraps) state_next = BK_PAD;
                    else                           state_next = BK_IDLE;
                end
            end
            BK_PAD:
            begin
                if (out_free && wraps) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        sub_index_next = sub_index_reg;
        sub_count_next = sub_count_reg;
        held_id_next   = held_id_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    idx_next = '0;
                    if (cmd.kind != CMD_DATA)
                    begin
                        pos_next       = POS_FIRST;
                        sub_index_next = '0;
                    end
                    if (cmd.kind == CMD_START)
                    begin
                        held_id_next   = cmd.id;
                        sub_count_next = cmd.count;
                    end
                end
            end
            BK_ERR:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_byte: 8'h00, frame_end: 1'b0,
                                       run_last: 1'b1, overflow_error: 1'b1};
                end
            end
            BK_HDR:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_byte: {type_code, sub_index_reg[1:0], sub_count_reg},
                                       frame_end: 1'b0, run_last: 1'b0, overflow_error: 1'b0};
                end
            end
            BK_ID:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_byte: held_id_reg, frame_end: 1'b0,
                                       run_last: 1'b0, overflow_error: 1'b0};
                end
            end
            BK_DATA:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_byte: cur_byte, frame_end: at_end,
                                       run_last: last_byte && !(cur_reg.finish && !wraps),
                                       overflow_error: 1'b0};
                    pos_next = pos_after;
                    idx_next = idx_reg + LIST_IW'(1);
                    if (at_end)
                    begin
                        sub_index_next = sub_index_reg + 3'd1;
                    end
                    // Message done on a frame boundary: rewind the index.
                    if (last_byte && cur_reg.finish && wraps)
                    begin
                        sub_index_next = '0;
                    end
                end
            end
            BK_PAD:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_byte: 8'h00, frame_end: at_end,
                                       run_last: wraps, overflow_error: 1'b0};
                    pos_next = pos_after;
                    if (wraps)
                    begin
                        sub_index_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= POS_FIRST;
            sub_index_reg <= '0;
            sub_count_reg <= '0;
            held_id_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sub_index_reg <= sub_index_next;
            sub_count_reg <= sub_count_next;
            held_id_reg   <= held_id_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== sv/routed_message_framer.sv =====
// Top level of the routed message framer: configuration registers and front/queue/back.
//
// A start transaction opens a message (id, payload length, route); each data
// transaction adds one payload byte. The block packs route hops, the end-of-route
// symbol, the length and the payload as two-bit symbols into stream bytes and cuts
// them into sub-messages of FRAME_BYTES bytes, each led by a header byte and the id
// byte, the last padded with zeros. A start that would need more than MAX_SUBFRAMES
// sub-messages yields a single overflow_error result and the message is dropped.
// Timing: the front takes one input transaction per cycle whenever the two-entry
// command queue has room. The back loads a queued command and then, while the result
// port is not stalled, writes one result byte per cycle into the result register: a
// data transaction writes its stream byte, led by header and id when it opens a
// sub-message, and the one that closes the message adds a flushed partial byte and
// the pad bytes. A start writes header, id and its complete route/length bytes, and
// more when it closes an empty message. With the back idle, an accepted transaction
// is registered in a queue entry, loaded into the back, then written as its first
// result into the result register. The back loads the next command only after the
// last result byte of the one before. Result stalls hold the back; the queue then
// fills and stalls the input. Configuration writes must happen only while idle.
module routed_message_framer #(
    parameter int FRAME_BYTES   = rmf_pkg::FRAME_BYTES_DEF,
    parameter int MAX_SUBFRAMES = rmf_pkg::MAX_SUBFRAMES_DEF,
    parameter int MAX_HOPS      = rmf_pkg::MAX_HOPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  rmf_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output rmf_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic [rmf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rmf_pkg::CFG_DW-1:0] cfg_data
);
    import rmf_pkg::*;

    logic [2:0] type_code_reg, type_code_next;
    logic [1:0] route_end_reg, route_end_next;

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_valid;
    cmd_t cmd_head;

    // Register writes; unknown indexes drop on the floor.
    always_comb
    begin
        type_code_next = type_code_reg;
        route_end_next = route_end_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TYPE_CODE: type_code_next = cfg_data[2:0];
                REG_ROUTE_END: route_end_next = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_code_reg <= TYPE_CODE_RST;
            route_end_reg <= ROUTE_END_RST;
        end
        else
        begin
            type_code_reg <= type_code_next;
            route_end_reg <= route_end_next;
        end
    end

    // Front: classify each transaction and pack its symbols.
    rmf_front #(
        .MAX_HOPS      (MAX_HOPS),
        .FRAME_BYTES   (FRAME_BYTES),
        .MAX_SUBFRAMES (MAX_SUBFRAMES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .route_end  (route_end_reg),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    // Queue: decouple front stalls from result stalls.
    rmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd_in),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head       (cmd_head)
    );

    // Back: frame stream bytes and emit results.
    rmf_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd_head),
        .cmd_pop      (cmd_pop),
        .type_code    (type_code_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== sv/rmf_checker.sv =====
// Port-level checks of the routed message framer and their bind.
module rmf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input rmf_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input rmf_pkg::result_t result
);

    // Hold a stalled input transaction.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input transaction changed or dropped");

    // Hold a stalled result transaction.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result transaction changed or dropped");

    // An overflow result stands alone: zero byte, no frame end, last of its run.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow_error |->
            result.run_last && !result.frame_end && (result.out_byte == 8'h00))
        else $error("malformed overflow result");

    // Come out of reset with the result register empty.
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule

bind routed_message_framer rmf_checker u_rmf_checker (.*);

// ===== tb/tb_routed_message_framer.sv =====
// Self-checking testbench for the routed message framer: directed table, then random traffic.
module tb_routed_message_framer;
    import rmf_pkg::*;

    // Block configuration under test; the instance below uses the same values.
    localparam int FRAME_BYTES   = FRAME_BYTES_DEF;
    localparam int MAX_SUBFRAMES = MAX_SUBFRAMES_DEF;
    localparam int MAX_HOPS      = MAX_HOPS_DEF;

    // Register indexes with no register behind them; writes to them must do nothing.
    localparam logic [CFG_IW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IW-1:0] REG_SPARE_B = 2'd3;

    // Upper bound on the results one transaction can cause.
    localparam int RUN_CAP = 34;
    // Quiet cycles after the last expected byte, covering ignored transactions in flight.
    localparam int SETTLE_CYCLES = 16;
    // Random phases, each with its own register setting and idling profile.
    localparam int PHASES = 4;
    localparam int PHASE_WORK = 15;
    // Hard stop: far beyond the slowest legal run with the longest stalls and gaps.
    localparam longint WATCHDOG = 64'd32_000_000;

    // How a directed row is checked.
    typedef enum {
        CHK_PRED,   // every result from the predictor
        CHK_NONE,   // transaction must cause no result
        CHK_FIRST   // first result typed in the row, the rest predicted
    } chk_t;

    typedef struct {
        item_t   stim;
        chk_t    chk;
        result_t first;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input is known from time zero.
    // ------------------------------------------------------------------
    logic              clk;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              cfg_we       = 1'b0;
    logic [CFG_IW-1:0] cfg_index    = '0;
    logic [CFG_DW-1:0] cfg_data     = '0;

    routed_message_framer #(
        .FRAME_BYTES   (FRAME_BYTES),
        .MAX_SUBFRAMES (MAX_SUBFRAMES),
        .MAX_HOPS      (MAX_HOPS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Framing predictor state: our own copy of registers and message progress.
    // ------------------------------------------------------------------
    logic [2:0] reg_type   = TYPE_CODE_RST;
    logic [1:0] reg_end    = ROUTE_END_RST;
    logic [7:0] acc_byte   = '0;       // stream byte being filled with symbols
    logic [1:0] acc_slot   = '0;       // next symbol slot in acc_byte
    logic [4:0] slot_pos   = POS_FIRST; // byte position inside the current sub-message
    logic [2:0] sub_idx    = '0;
    logic [2:0] sub_total  = '0;
    logic [7:0] left_bytes = '0;       // payload bytes still owed by the sender
    logic [7:0] cur_id     = '0;
    logic       msg_open   = 1'b0;

    result_t step_res[$];   // bytes caused by the transaction being predicted
    result_t bytes_due[$];  // bytes the block still owes, oldest first

    // Run statistics and failure tally.
    int n_bad      = 0;
    int n_work     = 0;
    int n_msg      = 0;
    int n_drop     = 0;
    int n_ignored  = 0;
    int n_results  = 0;
    int n_settings = 1;

    // 0: no idling, 1: light, 2: heavy. Shared by sender gaps and receiver stalls.
    int idle_mode = 0;

    function automatic void add_out(logic [7:0] b, logic fend, logic err);
        result_t r;
        r = '{out_byte: b, frame_end: fend, run_last: 1'b0, overflow_error: err};
        if (step_res.size() < RUN_CAP)
            step_res = {step_res, r};
    endfunction

    // Place one finished stream byte; open a sub-message with header and id first.
    function automatic void place_byte(logic [7:0] b);
        if (slot_pos == POS_FIRST)
        begin
            add_out({reg_type, sub_idx[1:0], sub_total}, 1'b0, 1'b0);
            add_out(cur_id, 1'b0, 1'b0);
        end
        if (int'(slot_pos) >= FRAME_BYTES - 1)
        begin
            add_out(b, 1'b1, 1'b0);
            slot_pos = POS_FIRST;
            sub_idx  = sub_idx + 3'd1;
        end
        else
        begin
            add_out(b, 1'b0, 1'b0);
            slot_pos = slot_pos + 5'd1;
        end
    endfunction

    // Pack one two-bit symbol, most significant slot first.
    function automatic void put_sym(logic [1:0] s);
        int sh;
        sh = 6 - 2 * int'(acc_slot);
        acc_byte = acc_byte | (8'(s) << sh);
        acc_slot = acc_slot + 2'd1;
        if (acc_slot == 2'd0)
        begin
            place_byte(acc_byte);
            acc_byte = '0;
        end
    endfunction

    function automatic void put_sym_byte(logic [7:0] v);
        put_sym(v[7:6]);
        put_sym(v[5:4]);
        put_sym(v[3:2]);
        put_sym(v[1:0]);
    endfunction

    // Flush the partial byte, pad the last sub-message with zeros, go idle.
    function automatic void close_msg();
        if (acc_slot != 2'd0)
        begin
            place_byte(acc_byte);
            acc_byte = '0;
            acc_slot = '0;
        end
        while (slot_pos != POS_FIRST)
            place_byte(8'h00);
        msg_open = 1'b0;
        sub_idx  = '0;
    endfunction

    // Work out every byte one accepted transaction causes, into step_res.
    function automatic void frame_item(item_t it);
        int      hops_used;
        int      n_sym;
        int      n_stream;
        int      n_sub;
        result_t tail;
        step_res.delete();
        if (it.op == OP_START)
        begin
            n_work++;
            hops_used = (int'(it.route_count) > MAX_HOPS) ? MAX_HOPS : int'(it.route_count);
            n_sym     = hops_used + 5 + 4 * int'(it.payload_length);
            n_stream  = (n_sym + 3) / 4;
            n_sub     = (n_stream + FRAME_BYTES - 3) / (FRAME_BYTES - 2);
            if (n_sub < 1)
                n_sub = 1;
            // A start always abandons whatever message was open.
            msg_open   = 1'b0;
            acc_byte   = '0;
            acc_slot   = '0;
            slot_pos   = POS_FIRST;
            sub_idx    = '0;
            left_bytes = '0;
            if (n_sub > MAX_SUBFRAMES)
            begin
                n_drop++;
                add_out(8'h00, 1'b0, 1'b1);
            end
            else
            begin
                n_msg++;
                cur_id     = it.message_id;
                sub_total  = 3'(n_sub);
                left_bytes = it.payload_length;
                msg_open   = 1'b1;
                for (int i = 0; i < hops_used; i++)
                    put_sym((i < 8) ? it.route_hops[15 - 2 * i -: 2] : 2'b00);
                put_sym(reg_end);
                put_sym_byte(it.payload_length);
                if (left_bytes == 8'd0)
                    close_msg();
            end
        end
        else if (msg_open)
        begin
            n_work++;
            put_sym_byte(it.payload_byte);
            if (left_bytes != 8'd0)
                left_bytes = left_bytes - 8'd1;
            if (left_bytes == 8'd0)
                close_msg();
        end
        else
        begin
            n_ignored++;
        end
        if (step_res.size() > 0)
        begin
            tail = step_res[$];
            tail.run_last = 1'b1;
            step_res[$] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t rand_item(logic op);
        item_t it;
        it.op             = op;
        it.message_id     = 8'($urandom);
        it.payload_length = 8'($urandom);
        it.route_hops     = 16'($urandom);
        it.route_count    = 4'($urandom);
        it.payload_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic item_t mk_start(logic [7:0] id, logic [7:0] len, logic [15:0] hops,
                                       logic [3:0] cnt);
        item_t it;
        it = rand_item(OP_START);
        it.message_id     = id;
        it.payload_length = len;
        it.route_hops     = hops;
        it.route_count    = cnt;
        return it;
    endfunction

    function automatic item_t mk_data(logic [7:0] b);
        item_t it;
        it = rand_item(OP_DATA);
        it.payload_byte = b;
        return it;
    endfunction

    // Idle length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0)
            return 0;
        if (idle_mode == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(8, 30);
    endfunction

    function automatic void note_bad(string what, result_t want, result_t got);
        n_bad++;
        if (n_bad <= 10)
        begin
            $write("mismatch at %0t (%s): expected byte %02h end %b last %b err %b,",
                   $time, what, want.out_byte, want.frame_end, want.run_last,
                   want.overflow_error);
            $display(" got byte %02h end %b last %b err %b",
                     got.out_byte, got.frame_end, got.run_last, got.overflow_error);
        end
    endfunction

    // Offer one transaction after a random gap, hold it until accepted, then predict.
    task automatic push_item(item_t it, chk_t chk, result_t typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        frame_item(it);
        // Rows with a hand-written first result take it in place of the predicted one.
        if (chk == CHK_FIRST)
        begin
            if (step_res.size() > 0)
                step_res[0] = typed;
            else
                step_res = {step_res, typed};
        end
        else if (chk == CHK_NONE)
        begin
            step_res.delete();
        end
        bytes_due = {bytes_due, step_res};
    endtask

    // Drop valid, wait for every owed byte, then let ignored work drain.
    task automatic settle();
        item_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers plus the two unused indexes, back to back, then release.
    task automatic write_regs(logic [2:0] type_val, logic [2:0] end_val);
        logic [CFG_IW-1:0] idx[4];
        logic [CFG_DW-1:0] dat[4];
        idx = '{REG_SPARE_A, REG_TYPE_CODE, REG_ROUTE_END, REG_SPARE_B};
        dat = '{3'($urandom), type_val, end_val, 3'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            @(posedge clk);
            if (idx[i] == REG_TYPE_CODE)
                reg_type = dat[i];
            else if (idx[i] == REG_ROUTE_END)
                reg_end = dat[i][1:0];
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // One random message: mostly well formed, some cut short, some too long to fit.
    task automatic send_message();
        item_t st;
        int    hops_used;
        int    len_max;
        int    len;
        int    r;
        int    n_send;
        if ($urandom_range(0, 99) < 8)
            push_item(rand_item(OP_DATA), CHK_PRED, '0);
        st = rand_item(OP_START);
        st.route_count = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 8))
                                                      : 4'($urandom_range(9, 15));
        hops_used = (int'(st.route_count) > MAX_HOPS) ? MAX_HOPS : int'(st.route_count);
        // Longest payload that still fits in MAX_SUBFRAMES sub-messages.
        len_max = ((FRAME_BYTES - 2) * MAX_SUBFRAMES * 4 - 5 - hops_used) / 4;
        r = $urandom_range(0, 99);
        if (r < 68)
            len = $urandom_range(0, 6);
        else if (r < 80)
            len = $urandom_range(7, 27);
        else if (r < 90)
            len = $urandom_range(28, len_max);
        else
            len = $urandom_range(len_max + 1, 255);
        st.payload_length = 8'(len);
        push_item(st, CHK_PRED, '0);
        if (len > len_max)
            n_send = $urandom_range(0, 2);       // trailing payload the block ignores
        else if (len == 0 || $urandom_range(0, 99) < 85)
            n_send = len;
        else
            n_send = $urandom_range(0, len - 1); // cut short; the next start abandons it
        repeat (n_send)
            push_item(rand_item(OP_DATA), CHK_PRED, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, always driven at the clock edge.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        logic hold;
        if (stall_left > 0)
        begin
            stall_left--;
            hold = 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            hold = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                hold = 1'b1;
            end
        end
        result_stall <= hold;
    end

    // Checker: each accepted result against the oldest owed byte, field by field.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (bytes_due.size() == 0)
            begin
                note_bad("result with nothing pending", '0, result);
            end
            else
            begin
                want = bytes_due.pop_front();
                if (want.out_byte !== result.out_byte || want.frame_end !== result.frame_end
                    || want.run_last !== result.run_last
                    || want.overflow_error !== result.overflow_error)
                    note_bad("field mismatch", want, result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    plan_row_t plan[$];

    function automatic void plan_add(item_t s, chk_t c, result_t f);
        plan_row_t row;
        row.stim  = s;
        row.chk   = c;
        row.first = f;
        plan = {plan, row};
    endfunction

    // Header byte as the first result of a message.
    function automatic result_t hdr_first(logic [7:0] b);
        result_t r;
        r = '{out_byte: b, frame_end: 1'b0, run_last: 1'b0, overflow_error: 1'b0};
        return r;
    endfunction

    initial
    begin
        int w0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration (type 2, route end 3), so headers
        // read 0x40 | count and a dropped start reads as a lone error byte.
        plan_add(mk_data(8'hFF), CHK_NONE, '0);                            // payload while idle
        plan_add(mk_start(8'h00, 8'd0, 16'h0000, 4'd0), CHK_FIRST, hdr_first(8'h41)); // empty
        plan_add(mk_start(8'hFF, 8'd2, 16'hFFFF, 4'd8), CHK_FIRST, hdr_first(8'h41)); // full route
        plan_add(mk_data(8'hFF), CHK_PRED, '0);
        plan_add(mk_data(8'h00), CHK_PRED, '0);
        plan_add(mk_start(8'h5A, 8'd255, 16'hAAAA, 4'd15), CHK_FIRST, 11'b0000_0000_011);
        plan_add(mk_data(8'h12), CHK_NONE, '0);                            // after a drop
        plan_add(mk_start(8'h3C, 8'd1, 16'h5555, 4'd15), CHK_PRED, '0);    // long route
        plan_add(mk_data(8'h81), CHK_PRED, '0);
        plan_add(mk_start(8'h11, 8'd3, 16'h1234, 4'd4), CHK_PRED, '0);
        plan_add(mk_data(8'h01), CHK_PRED, '0);
        plan_add(mk_start(8'h22, 8'd2, 16'h0000, 4'd1), CHK_PRED, '0);     // start while busy
        plan_add(mk_data(8'h7E), CHK_PRED, '0);
        plan_add(mk_data(8'hC3), CHK_PRED, '0);
        plan_add(mk_start(8'h77, 8'd118, 16'h0000, 4'd0), CHK_FIRST, hdr_first(8'h44)); // fit
        plan_add(mk_data(8'h55), CHK_PRED, '0);
        plan_add(mk_start(8'h80, 8'd119, 16'h0000, 4'd0), CHK_FIRST, 11'b0000_0000_011);
        plan_add(mk_start(8'h01, 8'd117, 16'hFFFF, 4'd8), CHK_FIRST, 11'b0000_0000_011);
        plan_add(mk_start(8'h01, 8'd116, 16'hFFFF, 4'd8), CHK_FIRST, hdr_first(8'h44));
        plan_add(mk_data(8'hFF), CHK_PRED, '0);
        plan_add(mk_start(8'h02, 8'd0, 16'hC000, 4'd3), CHK_PRED, '0);     // abandon, close
        plan_add(mk_data(8'hA5), CHK_NONE, '0);                            // idle again

        idle_mode = 1;
        foreach (plan[i])
            push_item(plan[i].stim, plan[i].chk, plan[i].first);
        settle();

        // Random phases: new register setting each time, extremes first.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: write_regs(3'd0, 3'd0);
                1: write_regs(3'd7, 3'd7);
                default: write_regs(3'($urandom), 3'($urandom));
            endcase
            idle_mode = (ph == 0) ? 0 : ((ph % 2 == 1) ? 2 : 1);
            w0 = n_work;
            while (n_work - w0 < PHASE_WORK)
                send_message();
            // Close a message left open by a cut-short sequence before touching registers.
            if (msg_open)
                push_item(mk_start(8'($urandom), 8'd0, 16'($urandom), 4'($urandom_range(0, 8))),
                          CHK_PRED, '0);
            settle();
        end

        $display("covered %0d transactions: %0d messages, %0d dropped, %0d ignored",
                 n_work + n_ignored, n_msg, n_drop, n_ignored);
        $display("checked %0d result bytes across %0d register settings, %0d mismatches",
                 n_results, n_settings, n_bad);
        if (n_bad == 0 && bytes_due.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            if (bytes_due.size() != 0)
                $display("%0d expected bytes never arrived", bytes_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(WATCHDOG);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rmf_pkg.sv
sv/rmf_front.sv
sv/rmf_queue.sv
sv/rmf_back.sv
sv/routed_message_framer.sv
sv/rmf_checker.sv
tb/tb_routed_message_framer.sv
